/* rtl/core/tiam_pkg.sv */
// Shared types and constants of the traffic interval anomaly monitor.
// No dependencies.
package tiam_pkg;

  localparam int unsigned FIG_N = 9;

  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [1:0] CFG_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_MARGIN   = 2'd1;

  localparam logic [31:0] INTERVAL_RESET = 32'd10000;
  localparam logic [9:0]  MARGIN_RESET   = 10'd30;

  typedef struct packed {
    logic        op;
    logic [31:0] src_addr;
    logic [15:0] pkt_len;
    logic        is_tcp;
    logic        is_syn;
  } item_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] pkts;
    logic [31:0] bytes;
    logic [31:0] tcp;
    logic [31:0] syn;
  } src_entry_t;

  function automatic logic [31:0] fig_offset(input logic [3:0] f);
    logic [31:0] r;
    case (f)
      4'd0:    r = 32'd10;
      4'd1:    r = 32'd100;
      4'd2:    r = 32'd1000000;
      4'd3:    r = 32'd50;
      4'd4:    r = 32'd50;
      4'd5:    r = 32'd300000;
      4'd6:    r = 32'd300000;
      4'd7:    r = 32'd100;
      4'd8:    r = 32'd100;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/tiam_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tiam_ram #(
  parameter int unsigned W = 32,
  parameter int unsigned D = 64
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);
  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/core/tiam_div.sv */
// Radix-2 restoring divider, 32-bit dividend, one quotient bit per cycle.
// No dependencies.
module tiam_div #(
  parameter int unsigned DVW = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [31:0]     dividend_i,
  input  logic [DVW-1:0]  divisor_i,
  output logic            done_o,
  output logic [31:0]     quotient_o
);
  logic [31:0]    quo_q, quo_d;
  logic [DVW-1:0] rem_q, rem_d;
  logic [DVW-1:0] dvs_q;
  logic [4:0]     cnt_q;
  logic           busy_q;
  logic [DVW:0]   trial;
  logic           fits;

  assign trial = {rem_q, quo_q[31]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    quo_d = {quo_q[30:0], fits};
    rem_d = fits ? DVW'(trial - {1'b0, dvs_q}) : trial[DVW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = quo_q;
endmodule

/* rtl/core/tiam_front.sv */
// Front end: two-entry request queue that decouples the input from the engine.
// Depends on tiam_pkg.
module tiam_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tiam_pkg::item_t item_i,
  output logic            full_o,
  output logic            valid_o,
  output tiam_pkg::item_t item_o,
  input  logic            pop_i
);
  tiam_pkg::item_t slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign item_o  = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wptr_q] <= item_i;
  end
endmodule

/* rtl/core/tiam_back.sv */
// Back end: source table lookup, interval close, history and anomaly check.
// Depends on tiam_pkg, tiam_ram and tiam_div.
module tiam_back #(
  parameter int unsigned SRC_N  = 64,
  parameter int unsigned HIST_N = 512
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         item_valid_i,
  input  tiam_pkg::item_t              item_i,
  output logic                         item_pop_o,
  input  logic [31:0]                  interval_ticks_i,
  input  logic [9:0]                   margin_percent_i,
  output logic                         res_valid_o,
  input  logic                         res_pop_i,
  output logic [31:0]                  res_fig_o [tiam_pkg::FIG_N],
  output logic [3:0]                   res_prop_o,
  output logic [$clog2(SRC_N+1)-1:0]   src_count_o,
  output logic [$clog2(HIST_N+1)-1:0]  hist_count_o
);
  localparam int unsigned SIW = $clog2(SRC_N);
  localparam int unsigned SCW = $clog2(SRC_N + 1);
  localparam int unsigned HIW = $clog2(HIST_N);
  localparam int unsigned HCW = $clog2(HIST_N + 1);
  localparam int unsigned DVW = (SCW > HCW) ? SCW : HCW;
  localparam int unsigned HW  = 32 * tiam_pkg::FIG_N;
  localparam logic [3:0] LAST_FIG = 4'(tiam_pkg::FIG_N - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN_RD, ST_SCAN_ACC, ST_DIV_PK, ST_DIV_BY, ST_OLD_RD, ST_OLD_SUB,
    ST_MEAN, ST_MUL, ST_CMP, ST_STORE, ST_LOOK_RD, ST_LOOK_CMP
  } state_e;

  state_e              state_q;
  tiam_pkg::item_t     pkt_q;
  logic [SCW-1:0]      cnt_q, idx_q;
  logic [31:0]         elapsed_q;
  logic                started_q;
  logic [HCW-1:0]      hcnt_q;
  logic [HIW-1:0]      head_q;
  logic [31:0]         sums_q [tiam_pkg::FIG_N];
  logic [31:0]         rec_q  [tiam_pkg::FIG_N];
  logic [3:0]          f_q, prop_q;
  logic [31:0]         mean_q;
  logic [42:0]         prod_q;
  logic [38:0]         lhs_q;
  logic                gt_q;
  logic                div_run_q;
  logic                out_valid_q;

  tiam_pkg::src_entry_t src_rd, src_wr;
  logic                 src_we;
  logic [HW-1:0]        hist_rd, hist_wr;
  logic                 hist_we;
  logic [HIW-1:0]       slot;
  logic [HCW:0]         slot_sum;
  logic                 div_start, div_done;
  logic [31:0]          div_dividend, div_quo;
  logic [DVW-1:0]       div_divisor;
  logic [31:0]          diff;

  tiam_ram #(.W($bits(tiam_pkg::src_entry_t)), .D(SRC_N)) u_src_ram (
    .clk_i, .we_i(src_we), .waddr_i(idx_q[SIW-1:0]), .wdata_i(src_wr),
    .raddr_i(idx_q[SIW-1:0]), .rdata_o(src_rd)
  );

  tiam_ram #(.W(HW), .D(HIST_N)) u_hist_ram (
    .clk_i, .we_i(hist_we), .waddr_i(slot), .wdata_i(hist_wr),
    .raddr_i(head_q), .rdata_o(hist_rd)
  );

  tiam_div #(.DVW(DVW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_dividend),
    .divisor_i(div_divisor), .done_o(div_done), .quotient_o(div_quo)
  );

  // Ring slot of the new record.
  always_comb begin
    slot_sum = (HCW+1)'(head_q) + (HCW+1)'(hcnt_q);
    if (slot_sum >= (HCW+1)'(HIST_N)) slot_sum = slot_sum - (HCW+1)'(HIST_N);
    slot = slot_sum[HIW-1:0];
  end

  always_comb begin
    for (int f = 0; f < tiam_pkg::FIG_N; f++) hist_wr[f*32 +: 32] = rec_q[f];
  end
  assign hist_we = (state_q == ST_STORE) && !out_valid_q;

  // Table write: bump a hit entry or append a new source.
  always_comb begin
    src_we = 1'b0;
    src_wr = src_rd;
    if (state_q == ST_LOOK_CMP && src_rd.addr == pkt_q.src_addr) begin
      src_we       = 1'b1;
      src_wr.pkts  = src_rd.pkts + 32'd1;
      src_wr.bytes = src_rd.bytes + 32'(pkt_q.pkt_len);
      src_wr.tcp   = src_rd.tcp + 32'(pkt_q.is_tcp);
      src_wr.syn   = src_rd.syn + 32'(pkt_q.is_syn);
    end else if (state_q == ST_LOOK_RD && idx_q == cnt_q) begin
      src_we = cnt_q < SCW'(SRC_N);
      src_wr = '{addr: pkt_q.src_addr, pkts: 32'd1, bytes: 32'(pkt_q.pkt_len),
                 tcp: 32'(pkt_q.is_tcp), syn: 32'(pkt_q.is_syn)};
    end
  end

  always_comb begin
    div_dividend = rec_q[1];
    div_divisor  = DVW'(cnt_q);
    case (state_q)
      ST_DIV_BY: div_dividend = rec_q[2];
      ST_MEAN: begin
        div_dividend = sums_q[f_q];
        div_divisor  = DVW'(hcnt_q);
      end
      default: ;
    endcase
  end
  assign div_start = !div_run_q && !div_done &&
                     ((state_q == ST_DIV_PK && cnt_q != '0) || state_q == ST_DIV_BY ||
                      state_q == ST_MEAN);

  assign diff       = rec_q[f_q] - tiam_pkg::fig_offset(f_q);
  assign item_pop_o = (state_q == ST_IDLE) && item_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      elapsed_q   <= '0;
      started_q   <= 1'b0;
      hcnt_q      <= '0;
      head_q      <= '0;
      f_q         <= '0;
      prop_q      <= '0;
      div_run_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int f = 0; f < tiam_pkg::FIG_N; f++) sums_q[f] <= '0;
    end else begin
      if (div_start) div_run_q <= 1'b1;
      else if (div_done) div_run_q <= 1'b0;
      if (res_pop_i && out_valid_q) out_valid_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (item_valid_i) begin
            idx_q <= '0;
            if (item_i.op == tiam_pkg::OP_TICK) begin
              if (elapsed_q != '1) elapsed_q <= elapsed_q + 32'd1;
            end else if (!started_q) begin
              started_q <= 1'b1;
              elapsed_q <= '0;
              state_q   <= ST_LOOK_RD;
            end else if (elapsed_q > interval_ticks_i) begin
              elapsed_q <= '0;
              state_q   <= ST_SCAN_RD;
            end else begin
              state_q <= ST_LOOK_RD;
            end
          end
        end
        ST_SCAN_RD: state_q <= (idx_q == cnt_q) ? ST_DIV_PK : ST_SCAN_ACC;
        ST_SCAN_ACC: begin
          idx_q   <= idx_q + SCW'(1);
          state_q <= ST_SCAN_RD;
        end
        ST_DIV_PK: begin
          if (cnt_q == '0) state_q <= ST_DIV_BY;
          else if (div_done) state_q <= ST_DIV_BY;
        end
        ST_DIV_BY: begin
          if (cnt_q == '0 || div_done) begin
            f_q    <= '0;
            prop_q <= '0;
            if (hcnt_q == HCW'(HIST_N)) state_q <= ST_OLD_RD;
            else if (hcnt_q != '0) state_q <= ST_MEAN;
            else state_q <= ST_STORE;
          end
        end
        ST_OLD_RD: state_q <= ST_OLD_SUB;
        ST_OLD_SUB: begin
          // Drop the oldest record.
          for (int f = 0; f < tiam_pkg::FIG_N; f++)
            sums_q[f] <= sums_q[f] - hist_rd[f*32 +: 32];
          head_q  <= (head_q == HIW'(HIST_N - 1)) ? '0 : head_q + HIW'(1);
          hcnt_q  <= HCW'(HIST_N - 1);
          state_q <= ST_MEAN;
        end
        ST_MEAN: if (div_done) state_q <= ST_MUL;
        ST_MUL:  state_q <= ST_CMP;
        ST_CMP: begin
          if (gt_q && {4'b0, lhs_q} > prod_q) begin
            prop_q  <= f_q + 4'd1;
            state_q <= ST_STORE;
          end else if (f_q == LAST_FIG) begin
            state_q <= ST_STORE;
          end else begin
            f_q     <= f_q + 4'd1;
            state_q <= ST_MEAN;
          end
        end
        ST_STORE: begin
          if (!out_valid_q) begin
            for (int f = 0; f < tiam_pkg::FIG_N; f++) sums_q[f] <= sums_q[f] + rec_q[f];
            hcnt_q      <= hcnt_q + HCW'(1);
            out_valid_q <= 1'b1;
            cnt_q       <= '0;
            idx_q       <= '0;
            state_q     <= ST_LOOK_RD;
          end
        end
        ST_LOOK_RD: begin
          if (idx_q == cnt_q) begin
            if (cnt_q < SCW'(SRC_N)) cnt_q <= cnt_q + SCW'(1);
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_LOOK_CMP;
          end
        end
        ST_LOOK_CMP: begin
          if (src_rd.addr == pkt_q.src_addr) begin
            state_q <= ST_IDLE;
          end else begin
            idx_q   <= idx_q + SCW'(1);
            state_q <= ST_LOOK_RD;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) pkt_q <= item_i;
        for (int f = 0; f < tiam_pkg::FIG_N; f++) rec_q[f] <= '0;
      end
      ST_SCAN_ACC: begin
        rec_q[1] <= rec_q[1] + src_rd.pkts;
        rec_q[2] <= rec_q[2] + src_rd.bytes;
        if (src_rd.pkts > rec_q[4])  rec_q[4] <= src_rd.pkts;
        if (src_rd.bytes > rec_q[6]) rec_q[6] <= src_rd.bytes;
        rec_q[7] <= rec_q[7] + src_rd.tcp;
        rec_q[8] <= rec_q[8] + src_rd.syn;
      end
      ST_DIV_PK: begin
        rec_q[0] <= 32'(cnt_q);
        if (div_done) rec_q[3] <= div_quo;
      end
      ST_DIV_BY: if (div_done) rec_q[5] <= div_quo;
      ST_MEAN:   if (div_done) mean_q <= div_quo;
      ST_MUL: begin
        prod_q <= 43'(mean_q) * 43'(11'(margin_percent_i) + 11'd100);
        lhs_q  <= 39'(diff) * 39'd100;
        gt_q   <= rec_q[f_q] > tiam_pkg::fig_offset(f_q);
      end
      ST_STORE: begin
        if (!out_valid_q) begin
          for (int f = 0; f < tiam_pkg::FIG_N; f++) res_fig_o[f] <= rec_q[f];
          res_prop_o <= prop_q;
        end
      end
      default: ;
    endcase
  end

  assign res_valid_o  = out_valid_q;
  assign src_count_o  = cnt_q;
  assign hist_count_o = hcnt_q;
endmodule

/* rtl/core/traffic_interval_anomaly_monitor.sv */
// Traffic interval anomaly monitor: per-interval source statistics with history check.
// A tick is handled in the engine's idle state; a packet searches the table entry by
// entry; an interval close scans every source, runs the divider for the mean
// packets and bytes per source, and checks up to 9 figures against their history means.
// Throughput is set by the table search loop and the shared bit-serial divider.
// Reset (async, active low) clears counters and control registers; no RAM clearing pass.
module traffic_interval_anomaly_monitor #(
  parameter int unsigned SOURCE_ENTRIES  = 64,
  parameter int unsigned HISTORY_ENTRIES = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel
  input  logic        push,
  output logic        full,
  input  logic        op_i,
  input  logic [31:0] src_addr_i,
  input  logic [15:0] pkt_len_i,
  input  logic        is_tcp_i,
  input  logic        is_syn_i,
  // Result channel
  output logic        empty,
  input  logic        pop,
  output logic [6:0]  unique_sources_o,
  output logic [31:0] packet_total_o,
  output logic [31:0] byte_total_o,
  output logic [31:0] mean_packets_per_source_o,
  output logic [31:0] peak_packets_per_source_o,
  output logic [31:0] mean_bytes_per_source_o,
  output logic [31:0] peak_bytes_per_source_o,
  output logic [31:0] tcp_total_o,
  output logic [31:0] syn_total_o,
  output logic [3:0]  anomaly_property_o,
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  tiam_pkg::item_t in_item, q_item;
  logic            q_valid, q_pop, res_valid;
  logic [31:0]     interval_q;
  logic [9:0]      margin_q;
  logic [31:0]     fig [tiam_pkg::FIG_N];
  logic [$clog2(SOURCE_ENTRIES+1)-1:0]  src_count;
  logic [$clog2(HISTORY_ENTRIES+1)-1:0] hist_count;

  // Config registers; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= tiam_pkg::INTERVAL_RESET;
      margin_q   <= tiam_pkg::MARGIN_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tiam_pkg::CFG_INTERVAL: interval_q <= cfg_data_i;
        tiam_pkg::CFG_MARGIN:   margin_q   <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  assign in_item = '{op: op_i, src_addr: src_addr_i, pkt_len: pkt_len_i,
                     is_tcp: is_tcp_i, is_syn: is_syn_i};

  // Front: hold incoming requests while the engine is busy.
  tiam_front u_front (
    .clk_i, .rst_ni, .push_i(push), .item_i(in_item), .full_o(full),
    .valid_o(q_valid), .item_o(q_item), .pop_i(q_pop)
  );

  // Back: lookup, close, history update and check; result held in an output register.
  tiam_back #(.SRC_N(SOURCE_ENTRIES), .HIST_N(HISTORY_ENTRIES)) u_back (
    .clk_i, .rst_ni, .item_valid_i(q_valid), .item_i(q_item), .item_pop_o(q_pop),
    .interval_ticks_i(interval_q), .margin_percent_i(margin_q),
    .res_valid_o(res_valid), .res_pop_i(pop), .res_fig_o(fig),
    .res_prop_o(anomaly_property_o), .src_count_o(src_count), .hist_count_o(hist_count)
  );

  assign empty                     = !res_valid;
  assign unique_sources_o          = fig[0][6:0];
  assign packet_total_o            = fig[1];
  assign byte_total_o              = fig[2];
  assign mean_packets_per_source_o = fig[3];
  assign peak_packets_per_source_o = fig[4];
  assign mean_bytes_per_source_o   = fig[5];
  assign peak_bytes_per_source_o   = fig[6];
  assign tcp_total_o               = fig[7];
  assign syn_total_o               = fig[8];

`ifndef SYNTH
  a_src_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    src_count <= ($clog2(SOURCE_ENTRIES+1))'(SOURCE_ENTRIES))
    else $error("source count past table size");
  a_hist_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_count <= ($clog2(HISTORY_ENTRIES+1))'(HISTORY_ENTRIES))
    else $error("history count past depth");
  a_prop_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> anomaly_property_o <= 4'd9)
    else $error("anomaly property out of range");
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(packet_total_o) && $stable(anomaly_property_o)))
    else $error("waiting result changed");
`endif
endmodule

/* dv/tb_traffic_interval_anomaly_monitor.sv */
// Self-checking testbench of the traffic interval anomaly monitor.
// Depends on tiam_pkg and traffic_interval_anomaly_monitor; drives requests,
// predicts each closed-interval record and compares it with the block's results.
module tb_traffic_interval_anomaly_monitor;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SRC_DEPTH  = 64;
  // Shallow history so that the ring wraps within a short run
  localparam int unsigned HIST_DEPTH = 32;
  // Index beyond the register map; the block must ignore the write
  localparam logic [1:0] CFG_UNMAPPED = 2'd3;
  localparam int unsigned IDLE_LIMIT  = 20000;
  // Worst engine time of one request (full table search plus a close)
  localparam int unsigned SETTLE_CYCLES = 800;

  typedef struct {
    logic [31:0] fig [tiam_pkg::FIG_N];
    logic [3:0]  prop;
  } interval_rec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        op_i = tiam_pkg::OP_TICK;
  logic [31:0] src_addr_i = '0;
  logic [15:0] pkt_len_i = '0;
  logic        is_tcp_i = 1'b0;
  logic        is_syn_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [6:0]  unique_sources_o;
  logic [31:0] packet_total_o, byte_total_o, mean_packets_per_source_o;
  logic [31:0] peak_packets_per_source_o, mean_bytes_per_source_o;
  logic [31:0] peak_bytes_per_source_o, tcp_total_o, syn_total_o;
  logic [3:0]  anomaly_property_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  traffic_interval_anomaly_monitor #(
    .SOURCE_ENTRIES(SRC_DEPTH), .HISTORY_ENTRIES(HIST_DEPTH)
  ) DUT (.*);

  always #10 clk_i = ~clk_i;

  // Mirror of the block's state, kept by the interval predictor
  logic [31:0] interval_ticks, margin_percent;
  logic [31:0] tab_addr [SRC_DEPTH];
  logic [31:0] tab_pkts [SRC_DEPTH];
  logic [31:0] tab_bytes [SRC_DEPTH];
  logic [31:0] tab_tcp [SRC_DEPTH];
  logic [31:0] tab_syn [SRC_DEPTH];
  int unsigned src_used, hist_used, hist_head;
  logic [31:0] elapsed;
  bit          started;
  logic [31:0] hist_fig [HIST_DEPTH][tiam_pkg::FIG_N];
  logic [31:0] hist_sum [tiam_pkg::FIG_N];

  interval_rec_t pending_records [$];
  int unsigned   errors = 0;
  bit            quiet = 1'b0;     // no idling on either side
  int unsigned   rx_hold = 0;      // long receiver hold-off, in cycles
  int unsigned   idle_cycles = 0;

  string fig_name [tiam_pkg::FIG_N] = '{"unique_sources", "packet_total", "byte_total",
    "mean_packets_per_source", "peak_packets_per_source", "mean_bytes_per_source",
    "peak_bytes_per_source", "tcp_total", "syn_total"};

  // Close the running interval: build the record, check it against history
  function automatic void close_interval_predict();
    interval_rec_t r;
    logic [31:0] pk = 0, by = 0, pmax = 0, bmax = 0, tc = 0, sy = 0;
    longint unsigned mean, lim;
    int unsigned slot;
    for (int i = 0; i < src_used; i++) begin
      pk += tab_pkts[i];
      by += tab_bytes[i];
      if (tab_pkts[i] > pmax) pmax = tab_pkts[i];
      if (tab_bytes[i] > bmax) bmax = tab_bytes[i];
      tc += tab_tcp[i];
      sy += tab_syn[i];
    end
    r.fig[0] = src_used;
    r.fig[1] = pk;
    r.fig[2] = by;
    r.fig[3] = src_used != 0 ? pk / src_used : 0;
    r.fig[4] = pmax;
    r.fig[5] = src_used != 0 ? by / src_used : 0;
    r.fig[6] = bmax;
    r.fig[7] = tc;
    r.fig[8] = sy;
    r.prop = 0;
    src_used = 0;
    // Drop the oldest record when history is full
    if (hist_used >= HIST_DEPTH) begin
      for (int f = 0; f < tiam_pkg::FIG_N; f++) hist_sum[f] -= hist_fig[hist_head][f];
      hist_head = (hist_head + 1) % HIST_DEPTH;
      hist_used = HIST_DEPTH - 1;
    end
    if (hist_used >= 1) begin
      for (int f = 0; f < tiam_pkg::FIG_N; f++) begin
        mean = hist_sum[f] / hist_used;
        lim = mean * (100 + margin_percent) / 100 + tiam_pkg::fig_offset(4'(f));
        if (r.prop == 0 && longint'(r.fig[f]) > lim) r.prop = 4'(f + 1);
      end
    end
    slot = (hist_head + hist_used) % HIST_DEPTH;
    for (int f = 0; f < tiam_pkg::FIG_N; f++) begin
      hist_fig[slot][f] = r.fig[f];
      hist_sum[f] += r.fig[f];
    end
    hist_used++;
    pending_records.push_back(r);
  endfunction

  function automatic void predict_request(tiam_pkg::item_t it);
    if (it.op == tiam_pkg::OP_TICK) begin
      if (elapsed != 32'hFFFF_FFFF) elapsed++;
      return;
    end
    if (!started) begin
      started = 1'b1;
      elapsed = 0;
    end else if (elapsed > interval_ticks) begin
      close_interval_predict();
      elapsed = 0;
    end
    for (int i = 0; i < src_used; i++) begin
      if (tab_addr[i] == it.src_addr) begin
        tab_pkts[i] += 1;
        tab_bytes[i] += it.pkt_len;
        tab_tcp[i] += it.is_tcp;
        tab_syn[i] += it.is_syn;
        return;
      end
    end
    // Drop packets from unknown sources once the table is full
    if (src_used < SRC_DEPTH) begin
      tab_addr[src_used] = it.src_addr;
      tab_pkts[src_used] = 1;
      tab_bytes[src_used] = it.pkt_len;
      tab_tcp[src_used] = it.is_tcp;
      tab_syn[src_used] = it.is_syn;
      src_used++;
    end
  endfunction

  // Offer one request; hold it until accepted, then predict it
  task automatic send_request(input tiam_pkg::item_t it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      @(negedge clk_i);
      push = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end else begin
      @(negedge clk_i);
    end
    push = 1'b1;
    op_i = it.op;
    src_addr_i = it.src_addr;
    pkt_len_i = it.pkt_len;
    is_tcp_i = it.is_tcp;
    is_syn_i = it.is_syn;
    do @(posedge clk_i); while (full);
    predict_request(it);
  endtask

  task automatic send_packet(input logic [31:0] a, input logic [15:0] len,
                             input logic tcp, input logic syn);
    tiam_pkg::item_t it;
    it = '{op: tiam_pkg::OP_PACKET, src_addr: a, pkt_len: len, is_tcp: tcp, is_syn: syn};
    send_request(it);
  endtask

  task automatic send_ticks(input int unsigned n);
    tiam_pkg::item_t it;
    it = '{op: tiam_pkg::OP_TICK, src_addr: $urandom, pkt_len: 16'($urandom),
           is_tcp: 1'($urandom), is_syn: 1'($urandom)};
    repeat (n) send_request(it);
  endtask

  // Hold the sender until every expected record has arrived and the engine settled
  task automatic wait_drained();
    @(negedge clk_i);
    push = 1'b0;
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == tiam_pkg::CFG_INTERVAL) interval_ticks = data;
    else if (idx == tiam_pkg::CFG_MARGIN) margin_percent = data[9:0];
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Result side: random pop stalls, plus the long hold-off when requested
  initial begin
    int unsigned stall;
    interval_rec_t exp_rec;
    logic [31:0] got [tiam_pkg::FIG_N];
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold != 0 || stall != 0) begin
        pop = 1'b0;
        if (stall != 0) stall--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        pop = 1'b0;
        stall = $urandom_range(0, 12);
      end else begin
        pop = 1'b1;
      end
      @(posedge clk_i);
      if (pop && !empty) begin
        got = '{32'(unique_sources_o), packet_total_o, byte_total_o,
                mean_packets_per_source_o, peak_packets_per_source_o,
                mean_bytes_per_source_o, peak_bytes_per_source_o, tcp_total_o,
                syn_total_o};
        if (pending_records.size() == 0) begin
          $error("unexpected record: packet_total %0d", packet_total_o);
          errors++;
        end else begin
          exp_rec = pending_records.pop_front();
          for (int f = 0; f < tiam_pkg::FIG_N; f++) begin
            if (got[f] !== exp_rec.fig[f]) begin
              $error("%s: expected %0d, got %0d", fig_name[f], exp_rec.fig[f], got[f]);
              errors++;
            end
          end
          if (anomaly_property_o !== exp_rec.prop) begin
            $error("anomaly_property: expected %0d, got %0d", exp_rec.prop,
                   anomaly_property_o);
            errors++;
          end
        end
      end
    end
  end

  // Count down the long receiver hold-off
  always @(posedge clk_i) if (rx_hold != 0) rx_hold <= rx_hold - 1;

  // Abort when no handshake of any kind happens for too long
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Ticks before the first packet, field extremes, flag combinations, first close
  task automatic test_first_interval();
    send_ticks(3);
    send_packet(32'h0, 16'h0, 1'b0, 1'b0);
    send_packet(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1);
    send_packet(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0);
    send_packet(32'h0, 16'h1, 1'b0, 1'b1);
    write_register(tiam_pkg::CFG_INTERVAL, 32'd1);
    write_register(tiam_pkg::CFG_MARGIN, 32'd0);
    write_register(CFG_UNMAPPED, 32'hFFFF_FFFF);
    send_ticks(1);
    send_packet(32'h5555_AAAA, 16'h8000, 1'b1, 1'b1);  // not yet past the interval
    send_ticks(2);
    send_packet(32'hAAAA_5555, 16'h7FFF, 1'b0, 1'b0);  // closes, no history yet
    send_ticks(2);
    send_packet(32'h1, 16'd10, 1'b0, 1'b0);            // small record, below mean
    repeat (4) send_packet(32'h2, 16'hFFFF, 1'b1, 1'b1);
    send_ticks(2);
    send_packet(32'h3, 16'd5, 1'b0, 1'b0);             // closes a large record
  endtask

  // More distinct sources than the table holds; the surplus is dropped
  task automatic test_table_full();
    for (int i = 0; i < 70; i++)
      send_packet(32'h0A00_0000 + i, 16'($urandom), 1'($urandom), 1'($urandom));
    send_packet(32'h0A00_0005, 16'd100, 1'b1, 1'b0);
    send_packet(32'h0A00_0045, 16'd100, 1'b1, 1'b0);
    send_ticks(2);
    send_packet(32'h0B00_0000, 16'd60, 1'b0, 1'b0);
  endtask

  // Register extremes: widest margin, and an interval that never closes
  task automatic test_register_extremes();
    write_register(tiam_pkg::CFG_MARGIN, 32'd1000);
    send_ticks(2);
    send_packet(32'h0C00_0001, 16'hFFFF, 1'b1, 1'b1);
    write_register(tiam_pkg::CFG_INTERVAL, 32'hFFFF_FFFF);
    send_ticks(5);
    send_packet(32'h0C00_0002, 16'd1, 1'b0, 1'b0);
    write_register(tiam_pkg::CFG_INTERVAL, 32'd0);  // below the legal range: closes after one tick
    send_ticks(1);
    send_packet(32'h0C00_0003, 16'd2, 1'b0, 1'b0);
    write_register(tiam_pkg::CFG_INTERVAL, 32'd1);
  endtask

  // Well-formed intervals with random content, some noise and outliers
  task automatic test_random_traffic();
    logic [31:0] pool [8];
    int unsigned sent, next_cfg, n_ticks;
    bit          held;
    sent = 0;
    next_cfg = 0;
    held = 1'b0;
    foreach (pool[i]) pool[i] = $urandom;
    while (sent < 185) begin
      if (sent >= next_cfg) begin
        write_register(tiam_pkg::CFG_MARGIN, 32'($urandom_range(0, 1000)));
        write_register(tiam_pkg::CFG_INTERVAL, 32'($urandom_range(1, 4)));
        next_cfg += 60;
      end
      if (!held && sent >= 90) begin
        rx_hold = 400;  // fill up and stall the input
        held = 1'b1;
      end
      repeat ($urandom_range(1, 10)) begin
        if ($urandom_range(0, 9) == 0)
          send_packet($urandom, 16'($urandom), 1'($urandom), 1'($urandom));
        else
          send_packet(pool[$urandom_range(0, 7)],
                      $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1500)),
                      1'($urandom), 1'($urandom));
        sent++;
      end
      n_ticks = $urandom_range(0, 6);
      send_ticks(n_ticks);
      sent += n_ticks;
    end
    wait_drained();  // sender pauses until every record is back
  endtask

  // Enough closes to wrap the history, with no idling on either side
  task automatic test_history_wrap();
    write_register(tiam_pkg::CFG_MARGIN, 32'd50);
    write_register(tiam_pkg::CFG_INTERVAL, 32'd1);
    quiet = 1'b1;
    repeat (HIST_DEPTH + 20) begin
      send_packet(32'h0D00_0000 + $urandom_range(0, 1), 16'($urandom_range(0, 1500)),
                  1'($urandom), 1'($urandom));
      send_ticks(2);
    end
    send_packet(32'h0D00_0001, 16'd64, 1'b0, 1'b0);
  endtask

  initial begin
    interval_ticks = tiam_pkg::INTERVAL_RESET;
    margin_percent = 32'(tiam_pkg::MARGIN_RESET);
    src_used = 0;
    hist_used = 0;
    hist_head = 0;
    elapsed = 0;
    started = 1'b0;
    foreach (hist_sum[f]) hist_sum[f] = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_first_interval();
    test_table_full();
    test_register_extremes();
    test_random_traffic();
    test_history_wrap();
    wait_drained();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
